// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the nearest point search block.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low asynchronous reset disable.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(expr), msg)

`endif

// File: hdl/npr_pkg.sv
// Types and constants for the nearest point within radius block.
// No dependencies; imported by nearest_point_within_radius.
`default_nettype none

package npr_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int ADDR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int COORD_W     = 16;
  localparam int SLOT_W      = 6;
  localparam int LIMIT_W     = 34;
  localparam int ACTIVE_W    = 7;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(6400);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_SQ_LIMIT = 2'd0,
    CFG_ACTIVE_POINTS   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    MODE_STORE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                      mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_index;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: hdl/nearest_point_within_radius.sv
// Nearest point within radius: point table in one synchronous RAM, scan pipeline.
// Depends on npr_pkg and assert_macros.svh.
// Store request: no response; the block stays idle, so stores can be accepted back to back.
// Query request: scans n = min(active_points, MAX_POINTS) entries, one RAM read per entry, 3-stage pipe;
// then loads the response once the output register is free and returns to idle to take the next request.
// Reset sets control and configuration to their reset values; the point table is not cleared.
`default_nettype none

module nearest_point_within_radius (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [npr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [npr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire npr_pkg::in_req_t               in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output npr_pkg::out_rsp_t                   out_rsp_o
);
  import npr_pkg::*;
  `include "assert_macros.svh"

  logic [SQ_W-1:0] mem [MAX_POINTS];

  state_e state_q, state_d;

  logic [LIMIT_W-1:0]  radius_q;
  logic [ACTIVE_W-1:0] active_q;

  logic                      in_ready;
  logic                      rd_en;
  logic                      load_out;
  logic                      accept;
  logic                      mem_we;
  logic [CNT_W-1:0]          n_sat;

  logic [CNT_W-1:0]          n_q;
  logic [CNT_W-1:0]          issue_cnt_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [LIMIT_W-1:0]        lim_q;
  logic [ADDR_W-1:0]         best_q;
  logic                      hit_q;

  logic                      v0_q, v1_q, v2_q;
  logic [ADDR_W-1:0]         idx0_q, idx1_q, idx2_q;
  logic [SQ_W-1:0]           rd_q;
  logic [COORD_W-1:0]        ax_q, ay_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic [SUM_W-1:0]          sum;
  logic                      closer;

  logic                      out_valid_q;
  out_rsp_t                  out_q;

  assign accept = in_valid_i && in_ready;
  assign mem_we = accept && (in_req_i.mode == MODE_STORE) &&
                  (32'(in_req_i.slot) < MAX_POINTS);
  assign n_sat  = (32'(active_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(active_q);

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i && (in_req_i.mode == MODE_QUERY)) begin
          state_d = (n_sat == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = (issue_cnt_q != n_q);
        if (!rd_en && !v0_q && !v1_q && !v2_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= LIMIT_RESET;
      active_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS_SQ_LIMIT: radius_q <= cfg_data_i;
        CFG_ACTIVE_POINTS:   active_q <= cfg_data_i[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Point table: x in the upper half, y in the lower half.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ADDR_W'(in_req_i.slot)] <= {in_req_i.coord_x, in_req_i.coord_y};
    end
    if (rd_en) begin
      rd_q <= mem[issue_cnt_q[ADDR_W-1:0]];
    end
  end

  assign dx  = {rd_q[SQ_W-1], rd_q[SQ_W-1:COORD_W]} - {px_q[COORD_W-1], px_q};
  assign dy  = {rd_q[COORD_W-1], rd_q[COORD_W-1:0]} - {py_q[COORD_W-1], py_q};
  assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;

  assign sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign closer = (LIMIT_W'(sum) < lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hit_q       <= 1'b0;
      issue_cnt_q <= '0;
      n_q         <= '0;
    end else begin
      v0_q <= rd_en;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if (accept && (in_req_i.mode == MODE_QUERY)) begin
        hit_q       <= 1'b0;
        issue_cnt_q <= '0;
        n_q         <= n_sat;
      end else begin
        if (rd_en) begin
          issue_cnt_q <= issue_cnt_q + CNT_W'(1);
        end
        if (v2_q && closer) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= issue_cnt_q[ADDR_W-1:0];
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    ax_q   <= adx[COORD_W-1:0];
    ay_q   <= ady[COORD_W-1:0];
    sqx_q  <= ax_q * ax_q;
    sqy_q  <= ay_q * ay_q;
    if (accept && (in_req_i.mode == MODE_QUERY)) begin
      px_q   <= in_req_i.coord_x;
      py_q   <= in_req_i.coord_y;
      lim_q  <= radius_q;
      best_q <= '0;
    end else if (v2_q && closer) begin
      lim_q  <= LIMIT_W'(sum);
      best_q <= idx2_q;
    end
  end

  // Hold the response until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.found       <= hit_q;
      out_q.match_index <= hit_q ? SLOT_W'(best_q) : '0;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT_PROP(a_pipe_in_scan, clk_i, rst_ni, v2_q |-> (state_q == ST_SCAN),
               "distance pipe active outside scan")
  `ASSERT_NEVER(a_issue_bound, clk_i, rst_ni, issue_cnt_q > n_q,
                "read issue count beyond scan length")
  `ASSERT_PROP(a_limit_monotone, clk_i, rst_ni,
               (state_q == ST_SCAN) |=> (lim_q <= $past(lim_q)),
               "search limit grew during scan")
  `ASSERT_PROP(a_load_response, clk_i, rst_ni, load_out |=>
               (out_valid_q && (out_q.found == $past(hit_q))),
               "response not loaded from scan result")

endmodule

`default_nettype wire

// File: tb/nearest_point_within_radius_tb.sv
// Testbench for nearest_point_within_radius: stores and queries under random idling.
// Checks each response against an in-bench nearest-point search; depends on npr_pkg.
`default_nettype none

module nearest_point_within_radius_tb;
  import npr_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int QUIET_CYCLES = MAX_POINTS + 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_req_t               in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_rsp_t              out_rsp_o;

  logic signed [COORD_W-1:0] stored_x [MAX_POINTS];
  logic signed [COORD_W-1:0] stored_y [MAX_POINTS];
  logic [LIMIT_W-1:0]        radius_limit;
  logic [ACTIVE_W-1:0]       scan_count;
  out_rsp_t                  pending_matches [$];
  int                        mismatches;
  int                        idle_cycles = 0;
  bit                        no_idle;

  nearest_point_within_radius dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int scan_depth();
    return (scan_count > MAX_POINTS) ? MAX_POINTS : int'(scan_count);
  endfunction

  function automatic out_rsp_t nearest_in_radius(logic signed [COORD_W-1:0] qx,
                                                 logic signed [COORD_W-1:0] qy);
    out_rsp_t        res;
    longint          dx;
    longint          dy;
    longint unsigned sq_dist;
    longint unsigned bound;
    res   = '0;
    bound = radius_limit;
    for (int i = 0; i < scan_depth(); i++) begin
      dx      = longint'(stored_x[i]) - longint'(qx);
      dy      = longint'(stored_y[i]) - longint'(qy);
      sq_dist = dx * dx + dy * dy;
      if (sq_dist < bound) begin
        bound           = sq_dist;
        res.found       = 1'b1;
        res.match_index = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter_coord(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom);
  endfunction

  // receiver: mostly ready, short and occasional long stalls
  initial begin
    int hold;
    int r;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (no_idle) begin
        hold = 0;
        out_ready_i <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(15, 80);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response: expected none, actual found=%0b index=%0d",
                 $time, out_rsp_o.found, out_rsp_o.match_index);
      end else begin
        want = pending_matches.pop_front();
        if (out_rsp_o.found !== want.found) begin
          mismatches++;
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, want.found, out_rsp_o.found);
        end
        if (out_rsp_o.match_index !== want.match_index) begin
          mismatches++;
          $display("%0t: match_index mismatch: expected %0d, actual %0d",
                   $time, want.match_index, out_rsp_o.match_index);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input in_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (req.mode == MODE_STORE) begin
      stored_x[req.slot] = req.coord_x;
      stored_y[req.slot] = req.coord_y;
    end else begin
      pending_matches.push_back(nearest_in_radius(req.coord_x, req.coord_y));
    end
  endtask

  task automatic store_point(input int slot, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    in_req_t req;
    req.mode    = MODE_STORE;
    req.slot    = SLOT_W'(slot);
    req.coord_x = x;
    req.coord_y = y;
    send_request(req);
  endtask

  task automatic query_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    in_req_t req;
    req.mode    = MODE_QUERY;
    req.slot    = SLOT_W'($urandom);
    req.coord_x = x;
    req.coord_y = y;
    send_request(req);
  endtask

  // hold off until every response is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_RADIUS_SQ_LIMIT: begin
        radius_limit = data[LIMIT_W-1:0];
      end
      CFG_ACTIVE_POINTS: begin
        scan_count = data[ACTIVE_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [LIMIT_W-1:0] lim, input int active);
    settle();
    write_reg(CFG_RADIUS_SQ_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_ACTIVE_POINTS, CFG_DATA_W'(active));
  endtask

  task automatic test_empty_scan();
    query_point(16'sd0, 16'sd0);
    query_point(16'sh7fff, -16'sh8000);
  endtask

  task automatic test_small_table();
    configure(LIMIT_RESET, 4);
    store_point(0, -16'sh8000, -16'sh8000);
    store_point(1, 16'sh7fff, 16'sh7fff);
    store_point(2, 16'sd10, -16'sd10);
    store_point(3, 16'sd10, -16'sd10);
    query_point(16'sd10, -16'sd10);
    query_point(16'sh7fff, 16'sh7fff);
    query_point(-16'sh8000, -16'sh8000);
    query_point(16'sd90, -16'sd10);
    query_point(16'sd89, -16'sd10);
  endtask

  task automatic test_spare_registers();
    settle();
    write_reg(CFG_IDX_SPARE_LO, '1);
    write_reg(CFG_IDX_SPARE_HI, '1);
    query_point(16'sh7fff, -16'sh8000);
    query_point(16'sd12, -16'sd8);
  endtask

  task automatic test_limit_extremes();
    configure('0, 4);
    query_point(16'sd10, -16'sd10);
    configure(LIMIT_MAX, 4);
    query_point(-16'sh8000, 16'sh7fff);
    query_point(16'sh7fff, -16'sh8000);
  endtask

  task automatic test_load_table();
    int cx [4];
    int cy [4];
    int r;
    int k;
    for (int c = 0; c < 4; c++) begin
      cx[c] = int'($urandom_range(0, 60000)) - 30000;
      cy[c] = int'($urandom_range(0, 60000)) - 30000;
    end
    for (int s = 0; s < MAX_POINTS; s++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 3);
      if (s > 0 && r < 15) begin
        k = $urandom_range(0, s - 1);
        store_point(s, stored_x[k], stored_y[k]);
      end else if (r < 35) begin
        store_point(s, any_coord(), any_coord());
      end else begin
        store_point(s, jitter_coord(cx[k], 400), jitter_coord(cy[k], 400));
      end
    end
  endtask

  task automatic test_saturation();
    configure(LIMIT_RESET, 127);
    query_point(stored_x[MAX_POINTS-1], stored_y[MAX_POINTS-1]);
    query_point(jitter_coord(stored_x[0], 60), jitter_coord(stored_y[0], 60));
    configure(LIMIT_MAX, 65);
    query_point(stored_x[MAX_POINTS-1], stored_y[MAX_POINTS-1]);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int active, input int count);
    int r;
    int s;
    int k;
    configure(lim, active);
    repeat (count) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, MAX_POINTS - 1);
      k = $urandom_range(0, MAX_POINTS - 1);
      if (r < 8) begin
        store_point(s, stored_x[k], stored_y[k]);
      end else if (r < 22) begin
        store_point(s, jitter_coord(stored_x[k], 300), jitter_coord(stored_y[k], 300));
      end else if (r < 30) begin
        store_point(s, any_coord(), any_coord());
      end else if (r < 90) begin
        if (scan_depth() > 0) k = $urandom_range(0, scan_depth() - 1);
        query_point(jitter_coord(stored_x[k], 120), jitter_coord(stored_y[k], 120));
      end else begin
        query_point(any_coord(), any_coord());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(LIMIT_RESET, 64, 50);
    run_phase(LIMIT_W'(2500), 1, 30);
    no_idle = 1'b1;
    run_phase(LIMIT_W'(40000), 127, 50);
    no_idle = 1'b0;
    run_phase('0, 64, 30);
    run_phase(LIMIT_MAX, 65, 40);
    run_phase({2'($urandom_range(0, 3)), 32'($urandom)}, $urandom_range(0, 64), 40);
    run_phase(LIMIT_W'($urandom_range(0, 200000)), $urandom_range(0, 127), 50);
    run_phase(LIMIT_RESET, 0, 20);
    run_phase(LIMIT_RESET, 64, 50);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_RADIUS_SQ_LIMIT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    radius_limit = LIMIT_RESET;
    scan_count   = '0;
    mismatches   = 0;
    no_idle      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_scan();
    test_small_table();
    test_spare_registers();
    test_limit_extremes();
    test_load_table();
    test_saturation();
    test_random_traffic();

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
